FILE: design/bcl1_pkg.sv
// Shared constants and helpers for the box-constrained L1 scalar solver.
`default_nettype none

package bcl1_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// entries in the queue between front and back, power of two
	localparam int QUEUE_DEPTH = 4;

	// classified item: magnitude, curvature, two bounds, three flags
	function automatic int item_bits(input int w);
		return 4 * w + 2;
	endfunction

endpackage

`default_nettype wire

FILE: design/box_constrained_l1_scalar_solver.sv
// Path: queue, then divider stages, then saturation stage, then output register.
// Throughput: one item per cycle; the divider pipeline retires one quotient bit per
// stage, so a new item enters each cycle the output side is not stalled.
// Reset: arst_n asynchronously clears the queue and all valid flags; payload
// registers are not reset.
`default_nettype none

module box_constrained_l1_scalar_solver #(
	parameter int DATA_WIDTH = bcl1_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = bcl1_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// input channel: one transfer per coordinate update
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [DATA_WIDTH-1:0] lin_coef,
	input  wire logic        [DATA_WIDTH-2:0] curvature,
	input  wire logic signed [DATA_WIDTH-1:0] lower_bound,
	input  wire logic signed [DATA_WIDTH-1:0] upper_bound,
	input  wire logic        [DATA_WIDTH-2:0] penalty,
	// output channel: one transfer per result
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed      [DATA_WIDTH-1:0] solution
);
	import bcl1_pkg::*;

	localparam int ITEM_W = item_bits(DATA_WIDTH);

	logic [ITEM_W-1:0] front_item;
	logic [ITEM_W-1:0] queue_item;
	logic              queue_full;
	logic              queue_valid;
	logic              back_take;

	// Front: soft threshold of -lin_coef by penalty, split into magnitude and
	// sign; flags zero magnitude and zero curvature so the back end can
	// saturate without looking at the divider result.
	bcl1_front #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.lin_coef    (lin_coef),
		.curvature   (curvature),
		.lower_bound (lower_bound),
		.upper_bound (upper_bound),
		.penalty     (penalty),
		.item        (front_item)
	);

	// Input is stalled only when the queue is full, so a transfer is taken
	// while the output side still holds a finished result.
	assign in_stall = queue_full;

	bcl1_queue #(
		.ITEM_W (ITEM_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_full  (queue_full),
		.push_data  (front_item),
		.pop_valid  (queue_valid),
		.pop_take   (back_take),
		.pop_data   (queue_item)
	);

	// Back: restoring divider, one bit per stage over DATA_WIDTH+FRAC_BITS
	// stages, then saturation to the signed range, then clamp to the box
	// into the output register.
	bcl1_back #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.deq_valid (queue_valid),
		.deq_take  (back_take),
		.deq_data  (queue_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.solution  (solution)
	);

endmodule

`default_nettype wire

FILE: design/bcl1_front.sv
// Front end: soft threshold of the linear term and item classification.
`default_nettype none

module bcl1_front #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic signed [DATA_WIDTH-1:0]               lin_coef,
	input  wire logic        [DATA_WIDTH-2:0]               curvature,
	input  wire logic signed [DATA_WIDTH-1:0]               lower_bound,
	input  wire logic signed [DATA_WIDTH-1:0]               upper_bound,
	input  wire logic        [DATA_WIDTH-2:0]               penalty,
	output logic       [bcl1_pkg::item_bits(DATA_WIDTH)-1:0] item
);
	import bcl1_pkg::*;

	typedef struct packed {
		logic        [DATA_WIDTH-1:0] mag;
		logic        [DATA_WIDTH-2:0] b;
		logic signed [DATA_WIDTH-1:0] lo;
		logic signed [DATA_WIDTH-1:0] hi;
		logic                         neg;
		logic                         zero;
		logic                         bzero;
	} item_t;

	item_t                 it;
	logic [DATA_WIDTH-1:0] lam_x;
	logic [DATA_WIDTH-1:0] abs_neg;

	assign lam_x   = {1'b0, penalty};
	// -a as unsigned; the most negative a maps to 2^(W-1), which fits
	assign abs_neg = '0 - lin_coef;

	always_comb begin
		it       = '0;
		it.b     = curvature;
		it.lo    = lower_bound;
		it.hi    = upper_bound;
		it.bzero = (curvature == '0);
		if (lin_coef[DATA_WIDTH-1]) begin
			if (abs_neg > lam_x) begin
				it.mag = abs_neg - lam_x;
			end
		end else if (lin_coef > lam_x) begin
			it.mag = lin_coef - lam_x;
			it.neg = 1'b1;
		end
		it.zero = (it.mag == '0);
	end

	assign item = it;

endmodule

`default_nettype wire

FILE: design/bcl1_queue.sv
// Small FIFO that decouples the front end from the divider pipeline.
`default_nettype none

module bcl1_queue #(
	parameter int ITEM_W = 130
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_full,
	input  wire logic [ITEM_W-1:0] push_data,
	output logic                   pop_valid,
	input  wire logic              pop_take,
	output logic      [ITEM_W-1:0] pop_data
);
	import bcl1_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [ITEM_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       count_q;
	logic              push;
	logic              pop;

	assign push_full = (count_q == (PW + 1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign push      = push_valid && !push_full;
	assign pop       = pop_take && pop_valid;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: design/bcl1_back.sv
// Back end: bit-per-stage divider pipeline, saturation and box clamp.
`default_nettype none

module bcl1_back #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          deq_valid,
	output logic                                               deq_take,
	input  wire logic [bcl1_pkg::item_bits(DATA_WIDTH)-1:0]    deq_data,
	output logic                                               out_valid,
	input  wire logic                                          out_stall,
	output logic signed [DATA_WIDTH-1:0]                       solution
);
	import bcl1_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam int N = DATA_WIDTH + FRAC_BITS;

	typedef struct packed {
		logic        [W-1:0] mag;
		logic        [W-2:0] b;
		logic signed [W-1:0] lo;
		logic signed [W-1:0] hi;
		logic                neg;
		logic                zero;
		logic                bzero;
	} item_t;

	logic en;

	// divider stage registers, one quotient bit per stage
	item_t        div_item_s [N];
	logic [W-2:0] div_rem_s  [N];
	logic [N-1:0] div_quo_s  [N];
	logic         div_vld_s  [N];

	// saturation stage
	logic signed [W-1:0] res_s1;
	logic signed [W-1:0] lo_s1;
	logic signed [W-1:0] hi_s1;
	logic                vld_s1;

	logic signed [W-1:0] solution_q;
	logic                out_valid_q;

	// whole pipeline moves together; frozen only when a result is held
	assign en       = !out_valid_q || !out_stall;
	assign deq_take = en;

	for (genvar i = 0; i < N; i++) begin : g_div
		item_t        it_in;
		logic [W-2:0] rem_in;
		logic [N-1:0] quo_in;
		logic         vld_in;
		logic         nbit;
		logic [W-1:0] trial;
		logic         ge;
		logic [W-1:0] diff;

		if (i == 0) begin : g_head
			assign it_in  = item_t'(deq_data);
			assign rem_in = '0;
			assign quo_in = '0;
			assign vld_in = deq_valid;
		end else begin : g_body
			assign it_in  = div_item_s[i-1];
			assign rem_in = div_rem_s[i-1];
			assign quo_in = div_quo_s[i-1];
			assign vld_in = div_vld_s[i-1];
		end

		// dividend is mag followed by FRAC_BITS zeros
		if (i < W) begin : g_mbit
			assign nbit = it_in.mag[W-1-i];
		end else begin : g_zbit
			assign nbit = 1'b0;
		end

		assign trial = {rem_in, nbit};
		assign ge    = (trial >= {1'b0, it_in.b});
		assign diff  = trial - {1'b0, it_in.b};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[i] <= 1'b0;
			end else if (en) begin
				div_vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_item_s[i] <= it_in;
				div_rem_s[i]  <= ge ? diff[W-2:0] : trial[W-2:0];
				div_quo_s[i]  <= {quo_in[N-2:0], ge};
			end
		end
	end

	item_t               last_it;
	logic [N:0]          quo_x;
	logic                pos_ovf;
	logic                neg_ovf;
	logic signed [W-1:0] res_d;
	logic signed [W-1:0] clamp_lo;
	logic signed [W-1:0] clamp_d;

	assign last_it = div_item_s[N-1];
	assign quo_x   = {1'b0, div_quo_s[N-1]};
	assign pos_ovf = |quo_x[N:W-1];
	assign neg_ovf = (|quo_x[N:W]) || (quo_x[W-1] && (|quo_x[W-2:0]));

	always_comb begin
		if (last_it.zero) begin
			res_d = '0;
		end else if (!last_it.neg) begin
			res_d = (last_it.bzero || pos_ovf) ? {1'b0, {(W-1){1'b1}}} : quo_x[W-1:0];
		end else begin
			res_d = (last_it.bzero || neg_ovf) ? {1'b1, {(W-1){1'b0}}}
				: ('0 - quo_x[W-1:0]);
		end
	end

	// lower clamp first, upper clamp last
	assign clamp_lo = (res_s1 < lo_s1) ? lo_s1 : res_s1;
	assign clamp_d  = (hi_s1 < clamp_lo) ? hi_s1 : clamp_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1      <= div_vld_s[N-1];
			out_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1     <= res_d;
			lo_s1      <= last_it.lo;
			hi_s1      <= last_it.hi;
			solution_q <= clamp_d;
		end
	end

	assign out_valid = out_valid_q;
	assign solution  = solution_q;

endmodule

`default_nettype wire
